>>> rtl/i2cbm_pkg.sv
// Shared types and constants for the I2C byte master.
`default_nettype none
package i2cbm_pkg;
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [2:0] CFG_LOW     = 3'd0;
    localparam logic [2:0] CFG_HIGH    = 3'd1;
    localparam logic [2:0] CFG_HOLD    = 3'd2;
    localparam logic [2:0] CFG_STRETCH = 3'd3;
    localparam logic [2:0] CFG_ACKPOLL = 3'd4;
    localparam logic [2:0] CFG_LINEWT  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_BYTE  = 2'd3;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_byte;
        logic       first_in_run;
        logic       ack_after_read;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] status;
    } out_item_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [1:0] kind;
        logic       is_read;
        logic [7:0] write_byte;
        logic       flag;
        logic       sda_sample;
    } cmd_t;
endpackage
`default_nettype wire

>>> rtl/i2cbm_front.sv
// Front end: classify input beats and queue them for the bit engine.
`default_nettype none
module i2cbm_front import i2cbm_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t item,
    input  wire logic     push,
    output logic          full,
    output cmd_t          cmd,
    output logic          cmd_valid,
    input  wire logic     cmd_take
);
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    cmd_t       c;
    logic       do_push, do_pop;

    always_comb
    begin
        c.write_byte     = item.write_byte;
        c.sda_sample     = item.sda_sample;
        c.is_read        = 1'b0;
        c.flag           = item.first_in_run;
        unique case (item.opcode)
            OP_START: c.kind = KIND_START;
            OP_STOP:  c.kind = KIND_STOP;
            OP_WRITE: c.kind = KIND_BYTE;
            OP_READ:
            begin
                c.kind    = KIND_BYTE;
                c.is_read = 1'b1;
                c.flag    = item.ack_after_read;
            end
            default:  c.kind = KIND_TICK;
        endcase
    end

    assign full      = cnt_reg[1];
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push) wr_reg <= !wr_reg;
            if (do_pop)  rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) q_reg[wr_reg] <= c;
    end
endmodule
`default_nettype wire

>>> rtl/i2cbm_engine.sv
// Back end: tick-driven I2C bit engine with a two-entry result queue.
`default_nettype none
module i2cbm_engine import i2cbm_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_take,
    input  wire logic [15:0] low_ticks,
    input  wire logic [15:0] high_ticks,
    input  wire logic [15:0] hold_ticks,
    input  wire logic [15:0] stretch_ticks,
    input  wire logic [15:0] ack_poll_limit,
    input  wire logic [15:0] line_wait_limit,
    output out_item_t        result,
    output logic             empty,
    input  wire logic        pop
);
    localparam int TW = TICK_COUNT_WIDTH;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    localparam logic [4:0] PH_IDLE = 5'd0, PH_START_A = 5'd1, PH_START_H = 5'd2,
        PH_STOP_A = 5'd3, PH_STOP_B = 5'd4, PH_W_STRETCH = 5'd5, PH_W_LOW = 5'd6,
        PH_W_HIGH = 5'd7, PH_W_ACKLOW = 5'd8, PH_W_ACKPOLL = 5'd9,
        PH_W_ACKHOLD = 5'd10, PH_R_STRETCH = 5'd11, PH_R_HIGH = 5'd12,
        PH_R_LOW = 5'd13, PH_R_ACKWAIT = 5'd14, PH_R_ACKHIGH = 5'd15;

    logic [4:0]    phase_reg, phase_next;
    logic [3:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    logic [TW-1:0] tick_reg, tick_next, tick_inc;
    logic [15:0]   wait_reg, wait_next, wait_inc;
    logic [1:0]    status_reg, status_next;
    logic          scl_reg, scl_next, sda_reg, sda_next;
    logic [1:0]    mode_reg, mode_next;
    logic [15:0]   dur;
    logic [TW-1:0] dur_c;
    logic          tdone, done, read_done;
    out_item_t     r;

    out_item_t  oq_reg [2];
    logic [1:0] ocnt_reg;
    logic       owr_reg, ord_reg;

    assign cmd_take = cmd_valid && !ocnt_reg[1];

    // Clip the duration to the counter range; zero acts as one tick.
    function automatic logic [TW-1:0] clip(input logic [15:0] d);
        logic [31:0]   w;
        logic [TW-1:0] v;
        w = {16'd0, d};
        if (w > 32'(TMAX)) v = TMAX;
        else v = w[TW-1:0];
        if (v == '0) v = {{(TW-1){1'b0}}, 1'b1};
        return v;
    endfunction

    always_comb
    begin
        unique case (phase_reg)
            PH_START_H, PH_STOP_A, PH_STOP_B:   dur = hold_ticks;
            PH_W_STRETCH, PH_R_STRETCH:          dur = stretch_ticks;
            PH_W_LOW, PH_W_ACKLOW, PH_R_LOW:     dur = low_ticks;
            default:                             dur = high_ticks;
        endcase
        dur_c    = clip(dur);
        tick_inc = (tick_reg < TMAX) ? tick_reg + 1'b1 : tick_reg;
        tdone    = tick_inc >= dur_c;
        wait_inc = wait_reg + 16'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        tick_next   = tick_reg;
        wait_next   = wait_reg;
        status_next = status_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        mode_next   = mode_reg;
        done        = 1'b0;
        read_done   = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            tick_next = '0;
            unique case (cmd.kind)
                KIND_START:
                begin
                    status_next = ST_OK; mode_next = 2'b00;
                    scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_START_A;
                end
                KIND_STOP:
                begin
                    status_next = ST_OK; mode_next = 2'b00;
                    sda_next = 1'b0; phase_next = PH_STOP_A;
                end
                KIND_BYTE:
                begin
                    status_next = ST_OK;
                    mode_next   = {cmd.is_read, cmd.flag};
                    bit_next    = 4'd0;
                    if (cmd.is_read)
                    begin
                        shift_next = 8'd0; sda_next = 1'b1;
                        if (stretch_ticks == 16'd0)
                        begin
                            scl_next = 1'b1; phase_next = PH_R_HIGH;
                        end
                        else phase_next = PH_R_STRETCH;
                    end
                    else
                    begin
                        shift_next = cmd.write_byte;
                        if (stretch_ticks == 16'd0)
                        begin
                            scl_next = 1'b0; sda_next = cmd.write_byte[7];
                            phase_next = PH_W_LOW;
                        end
                        else phase_next = PH_W_STRETCH;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            tick_next = tick_inc;
            unique case (phase_reg)
                PH_START_A:
                begin
                    sda_next = 1'b0; phase_next = PH_START_H; tick_next = '0;
                end
                PH_START_H, PH_W_ACKHOLD:
                    if (tdone)
                    begin
                        scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                        tick_next = '0;
                    end
                PH_STOP_A:
                    if (tdone)
                    begin
                        scl_next = 1'b1; phase_next = PH_STOP_B; tick_next = '0;
                    end
                PH_STOP_B:
                    if (tdone)
                    begin
                        sda_next = 1'b1; phase_next = PH_IDLE; done = 1'b1;
                        read_done = mode_reg[1]; tick_next = '0;
                    end
                PH_W_STRETCH:
                    if (tdone)
                    begin
                        scl_next = 1'b0; sda_next = shift_reg[7]; bit_next = 4'd0;
                        phase_next = PH_W_LOW; tick_next = '0;
                    end
                PH_W_LOW:
                    if (tdone)
                    begin
                        scl_next = 1'b1; phase_next = PH_W_HIGH; tick_next = '0;
                    end
                PH_W_HIGH:
                    if (tdone)
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_reg + 4'd1;
                        scl_next   = 1'b0;
                        tick_next  = '0;
                        if (bit_next >= 4'd8)
                        begin
                            sda_next = 1'b1; phase_next = PH_W_ACKLOW;
                        end
                        else
                        begin
                            sda_next = shift_reg[6]; phase_next = PH_W_LOW;
                        end
                    end
                PH_W_ACKLOW:
                    if (tdone)
                    begin
                        scl_next = 1'b1; wait_next = 16'd0;
                        phase_next = PH_W_ACKPOLL; tick_next = '0;
                    end
                PH_W_ACKPOLL:
                begin
                    tick_next = tick_reg;
                    if (!cmd.sda_sample)
                    begin
                        status_next = ST_OK; phase_next = PH_W_ACKHOLD; tick_next = '0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= ((ack_poll_limit == 16'd0) ? 16'd1 : ack_poll_limit))
                        begin
                            status_next = mode_reg[0] ? ST_TIMEOUT : ST_FAIL;
                            scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                            tick_next = '0;
                        end
                    end
                end
                PH_R_STRETCH:
                    if (tdone)
                    begin
                        scl_next = 1'b1; bit_next = 4'd0;
                        phase_next = PH_R_HIGH; tick_next = '0;
                    end
                PH_R_HIGH:
                    if (tdone)
                    begin
                        shift_next = {shift_reg[6:0], cmd.sda_sample};
                        bit_next   = bit_reg + 4'd1;
                        scl_next   = 1'b0;
                        tick_next  = '0;
                        if (bit_next >= 4'd8)
                        begin
                            sda_next = !mode_reg[0]; wait_next = 16'd0;
                            phase_next = PH_R_ACKWAIT;
                        end
                        else phase_next = PH_R_LOW;
                    end
                PH_R_LOW:
                    if (tdone)
                    begin
                        scl_next = 1'b1; phase_next = PH_R_HIGH; tick_next = '0;
                    end
                PH_R_ACKWAIT:
                begin
                    tick_next = tick_reg;
                    if (cmd.sda_sample == sda_reg)
                    begin
                        scl_next = 1'b1; phase_next = PH_R_ACKHIGH; tick_next = '0;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= ((line_wait_limit == 16'd0) ? 16'd1
                                                                   : line_wait_limit))
                        begin
                            scl_next = 1'b1; phase_next = PH_R_ACKHIGH; tick_next = '0;
                        end
                    end
                end
                PH_R_ACKHIGH:
                    if (tdone)
                    begin
                        scl_next = 1'b0; tick_next = '0;
                        if (mode_reg[0])
                        begin
                            phase_next = PH_IDLE; done = 1'b1; read_done = 1'b1;
                        end
                        else
                        begin
                            sda_next = 1'b0; phase_next = PH_STOP_A;
                        end
                    end
                default:
                begin
                    phase_next = PH_IDLE; tick_next = '0;
                end
            endcase
        end
        r.scl_level = scl_next;
        r.sda_level = sda_next;
        r.ready_res = phase_next == PH_IDLE;
        r.done_res  = done;
        r.read_data = read_done ? shift_next : 8'd0;
        r.status    = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; bit_reg <= 4'd0; shift_reg <= 8'd0;
            tick_reg <= '0; wait_reg <= 16'd0; status_reg <= ST_OK;
            scl_reg <= 1'b1; sda_reg <= 1'b1; mode_reg <= 2'b00;
        end
        else if (cmd_take)
        begin
            phase_reg <= phase_next; bit_reg <= bit_next; shift_reg <= shift_next;
            tick_reg <= tick_next; wait_reg <= wait_next; status_reg <= status_next;
            scl_reg <= scl_next; sda_reg <= sda_next; mode_reg <= mode_next;
        end
    end

    assign empty  = ocnt_reg == 2'd0;
    assign result = oq_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= 2'd0; owr_reg <= 1'b0; ord_reg <= 1'b0;
        end
        else
        begin
            ocnt_reg <= ocnt_reg + {1'b0, cmd_take} - {1'b0, pop && !empty};
            if (cmd_take) owr_reg <= !owr_reg;
            if (pop && !empty) ord_reg <= !ord_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take) oq_reg[owr_reg] <= r;
    end
endmodule
`default_nettype wire

>>> rtl/i2c_byte_master.sv
// Top level of the tick-driven I2C byte master.
//
// Usage: each input beat is one time tick or one command (start, stop,
// write byte, read byte) together with the sampled SDA level. Push a beat
// while full is low; every beat yields exactly one result beat, read while
// empty is low and taken with pop.
// The front end classifies beats into a two-entry command queue; the bit
// engine consumes one queued beat per cycle while the result queue is not
// full and writes its result into a two-entry result queue. Throughput is
// one beat per cycle unless the receiver stalls. A pushed beat goes through
// the command queue register, then the result queue register, to its result.
// When the receiver stalls, the result queue fills, the engine holds its
// state, the command queue fills and full rises; nothing is lost.
// Configuration writes go through cfg_valid/cfg_ready (always ready) and
// must be issued only while the block is idle.
// Reset: all timing registers return to defaults (5,5,5,7,100,1000), the
// engine returns to idle with SCL and SDA released, and both queues empty.
`default_nettype none
module i2c_byte_master import i2cbm_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_item_t    in_item,
    input  wire logic        push,
    output logic             full,
    output out_item_t        out_item,
    output logic             empty,
    input  wire logic        pop,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0] low_reg, high_reg, hold_reg, stretch_reg, ackpoll_reg, linewt_reg;
    cmd_t        cmd;
    logic        cmd_valid, cmd_take;

    assign cfg_ready = 1'b1;

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= 16'd5; high_reg <= 16'd5; hold_reg <= 16'd5;
            stretch_reg <= 16'd7; ackpoll_reg <= 16'd100; linewt_reg <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOW:     low_reg     <= cfg_data;
                CFG_HIGH:    high_reg    <= cfg_data;
                CFG_HOLD:    hold_reg    <= cfg_data;
                CFG_STRETCH: stretch_reg <= cfg_data;
                CFG_ACKPOLL: ackpoll_reg <= cfg_data;
                CFG_LINEWT:  linewt_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cbm_front u_front (
        .clk(clk), .rst_n(rst_n), .item(in_item), .push(push), .full(full),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    i2cbm_engine #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .low_ticks(low_reg), .high_ticks(high_reg),
        .hold_ticks(hold_reg), .stretch_ticks(stretch_reg),
        .ack_poll_limit(ackpoll_reg), .line_wait_limit(linewt_reg),
        .result(out_item), .empty(empty), .pop(pop)
    );
endmodule
`default_nettype wire
